/* design/gmkx_pkg.sv */
// Package for the GF(2) matrix keystream cipher: widths, seed reset value,
// the 32x32 matrix rows and the state advance / byte fold functions.
// No dependencies.
`default_nettype none

package gmkx_pkg;

  localparam int unsigned StateW = 32;
  localparam int unsigned ByteW  = 8;

  typedef logic [StateW-1:0] state_t;
  typedef logic [ByteW-1:0]  byte_t;

  localparam state_t SEED_RESET = 32'd1843441187;

  // Row k is selected by state bit k.
  localparam state_t GAL_ROWS [StateW] = '{
    32'd3193055860, 32'd971011855,  32'd1942023710, 32'd3884047420,
    32'd2319948703, 32'd1372263641, 32'd2744527282, 32'd40398979,
    32'd80797958,   32'd161595916,  32'd323191832,  32'd646383664,
    32'd1292767328, 32'd2585534656, 32'd1903977063, 32'd3807954126,
    32'd2159389307, 32'd1143961361, 32'd2287922722, 32'd1442447267,
    32'd2884894534, 32'd312728939,  32'd625457878,  32'd1250915756,
    32'd2501831512, 32'd1870263639, 32'd3740527278, 32'd4171495099,
    32'd3020148369, 32'd759414469,  32'd1518828938, 32'd3037657876
  };

  // GF(2) vector-matrix product: XOR of the rows picked by set bits.
  function automatic state_t advance(input state_t v);
    state_t acc;
    acc = '0;
    for (int k = 0; k < StateW; k++) begin
      acc ^= GAL_ROWS[k] & {StateW{v[k]}};
    end
    return acc;
  endfunction

  // XOR of the four bytes of the state.
  function automatic byte_t fold_bytes(input state_t v);
    return v[7:0] ^ v[15:8] ^ v[23:16] ^ v[31:24];
  endfunction

endpackage

`default_nettype wire

/* design/gmkx_advance.sv */
// One cipher step: next state from the matrix product and the output byte.
// Depends on gmkx_pkg.
`default_nettype none

module gmkx_advance (
  input  wire gmkx_pkg::state_t state_i,
  input  wire gmkx_pkg::byte_t  data_i,
  output gmkx_pkg::state_t      next_state_o,
  output gmkx_pkg::byte_t       out_byte_o
);

  gmkx_pkg::state_t next_state;

  assign next_state   = gmkx_pkg::advance(state_i);
  assign next_state_o = next_state;
  assign out_byte_o   = data_i ^ gmkx_pkg::fold_bytes(next_state);

endmodule

`default_nettype wire

/* design/gmkx_out_stage.sv */
// Output register stage with valid/ready; takes a new byte whenever it is
// empty or being drained. Depends on gmkx_pkg.
`default_nettype none

module gmkx_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire gmkx_pkg::byte_t in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output gmkx_pkg::byte_t      out_data_o
);

  logic            valid_q, valid_d;
  gmkx_pkg::byte_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

/* design/gf_matrix_keystream_xor_top.sv */
// Output: an accepted byte is registered and on m_axis in the next cycle.
// Throughput: one byte per cycle while not stalled; the state register feeds
//   the 32x32 GF(2) AND-XOR tree, written back in the cycle a byte is taken.
// Stalls: s_axis_tready follows m_axis_tready while the result register is full.
// Reset: asynchronous, active low; state loads the seed reset value, result
//   register empties. A seed write reloads the state at once.
// Depends on gmkx_pkg, gmkx_advance, gmkx_out_stage.
`default_nettype none

module gf_matrix_keystream_xor_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  // Seed write channel
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [31:0] cfg_data_i,      // [31:0] seed
  // Input byte stream
  input  wire        s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  wire [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  // Result byte stream
  output logic       m_axis_tvalid_o,
  input  wire        m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [7:0] out_byte
);

  gmkx_pkg::state_t state_q, state_d;
  gmkx_pkg::state_t next_state;
  gmkx_pkg::byte_t  out_byte;
  logic             in_accept;
  logic             cfg_accept;

  // The seed is only ever needed to (re)load the state, so it is not kept.
  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_accept   = s_axis_tvalid_i && s_axis_tready_o;

  gmkx_advance u_advance (
    .state_i      (state_q),
    .data_i       (s_axis_tdata_i),
    .next_state_o (next_state),
    .out_byte_o   (out_byte)
  );

  // Seed write wins; writes must come only while idle; the block does not enforce it.
  always_comb begin
    state_d = state_q;
    priority if (cfg_accept) begin
      state_d = cfg_data_i;
    end else if (in_accept) begin
      state_d = next_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gmkx_pkg::SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  gmkx_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (out_byte),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // Seed write lands in the state register.
  a_cfg_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_accept |=> state_q == $past(cfg_data_i))
    else $error("seed write not loaded into state");

  // An accepted byte advances the state by one matrix step.
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !cfg_accept) |=> state_q == gmkx_pkg::advance($past(state_q)))
    else $error("state did not advance on accepted byte");

  // Every accepted byte yields a pending result.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid_o)
    else $error("accepted byte produced no result");

  // State holds when nothing is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_accept && !cfg_accept) |=> $stable(state_q))
    else $error("state changed without a request");

endmodule

`default_nettype wire
